// ===== rtl/core/md5bc_pkg.sv =====
// Shared types, constants and round functions of the MD5 compression block.
package md5bc_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LOAD,
    ST_PRIME,
    ST_ROUND,
    ST_FOLD
  } seq_state_e;

  typedef struct packed {
    logic       load_iv;
    logic       load_work;
    logic       prime;
    logic       round;
    logic       fold;
    logic       out_load;
    logic [5:0] rnd;
  } dp_ctl_t;

  localparam logic [WordW-1:0] IV_A = 32'h67452301;
  localparam logic [WordW-1:0] IV_B = 32'hefcdab89;
  localparam logic [WordW-1:0] IV_C = 32'h98badcfe;
  localparam logic [WordW-1:0] IV_D = 32'h10325476;

  localparam logic [WordW-1:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0:    return lo;
      2'd1:    return 4'((lo << 2) + lo + 4'd1);
      2'd2:    return 4'((lo << 1) + lo + 4'd5);
      default: return 4'((lo << 3) - lo);
    endcase
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    unique case ({r[5:4], r[1:0]})
      4'h0: return 5'd7;
      4'h1: return 5'd12;
      4'h2: return 5'd17;
      4'h3: return 5'd22;
      4'h4: return 5'd5;
      4'h5: return 5'd9;
      4'h6: return 5'd14;
      4'h7: return 5'd20;
      4'h8: return 5'd4;
      4'h9: return 5'd11;
      4'ha: return 5'd16;
      4'hb: return 5'd23;
      4'hc: return 5'd6;
      4'hd: return 5'd10;
      4'he: return 5'd15;
      default: return 5'd21;
    endcase
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [1:0]       phase,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    unique case (phase)
      2'd0:    return (b & c) | (~b & d);
      2'd1:    return (b & d) | (c & ~d);
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [4:0]       s);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} << s;
    return dbl[2*WordW-1:WordW];
  endfunction

endpackage

// ===== rtl/core/md5bc_if.sv =====
// Handshake channels for message words and digests.
interface md5bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        start_message;
  logic        end_message;

  modport source(output valid, output message_word, output start_message,
                 output end_message, input ready);
  modport sink(input valid, input message_word, input start_message,
               input end_message, output ready);
endinterface

interface md5bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source(output valid, output digest_a, output digest_b, output digest_c,
                 output digest_d, input ready);
  modport sink(input valid, input digest_a, input digest_b, input digest_c,
               input digest_d, output ready);
endinterface

// ===== rtl/core/md5bc_msg_mem.sv =====
// Sixteen-word block buffer with one write port and one registered read port.
module md5bc_msg_mem import md5bc_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [3:0]       wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  input  logic [3:0]       rd_addr_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem_q [16];
  logic [WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/md5bc_datapath.sv =====
// Working and chaining registers around one shared MD5 round unit.
module md5bc_datapath import md5bc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_ctl_t          ctl_i,
  input  logic [WordW-1:0] word_i,
  output logic [WordW-1:0] digest_a_o,
  output logic [WordW-1:0] digest_b_o,
  output logic [WordW-1:0] digest_c_o,
  output logic [WordW-1:0] digest_d_o
);

  logic [WordW-1:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
  logic [WordW-1:0] a_q, b_q, c_q, d_q;
  logic [WordW-1:0] pre_q, pre_d;
  logic [WordW-1:0] dig_a_q, dig_b_q, dig_c_q, dig_d_q;
  logic [WordW-1:0] f_val, sum_val, b_new;
  logic [WordW-1:0] fold_a, fold_b, fold_c, fold_d;
  logic [5:0]       rnd_next;

  always_comb begin
    rnd_next = 6'(ctl_i.rnd + 6'd1);
    f_val    = round_f(ctl_i.rnd[5:4], b_q, c_q, d_q);
    sum_val  = f_val + pre_q;
    b_new    = b_q + rotl(sum_val, rot_amt(ctl_i.rnd));
    if (ctl_i.prime) begin
      pre_d = a_q + SINE_K[0] + word_i;
    end else begin
      pre_d = d_q + SINE_K[rnd_next] + word_i;
    end
    fold_a = ch_a_q + a_q;
    fold_b = ch_b_q + b_q;
    fold_c = ch_c_q + c_q;
    fold_d = ch_d_q + d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_a_q <= IV_A;
      ch_b_q <= IV_B;
      ch_c_q <= IV_C;
      ch_d_q <= IV_D;
    end else if (ctl_i.load_iv) begin
      ch_a_q <= IV_A;
      ch_b_q <= IV_B;
      ch_c_q <= IV_C;
      ch_d_q <= IV_D;
    end else if (ctl_i.fold) begin
      ch_a_q <= fold_a;
      ch_b_q <= fold_b;
      ch_c_q <= fold_c;
      ch_d_q <= fold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_work) begin
      a_q <= ch_a_q;
      b_q <= ch_b_q;
      c_q <= ch_c_q;
      d_q <= ch_d_q;
    end else if (ctl_i.round) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
    if (ctl_i.prime || ctl_i.round) begin
      pre_q <= pre_d;
    end
    if (ctl_i.out_load) begin
      dig_a_q <= fold_a;
      dig_b_q <= fold_b;
      dig_c_q <= fold_c;
      dig_d_q <= fold_d;
    end
  end

  assign digest_a_o = dig_a_q;
  assign digest_b_o = dig_b_q;
  assign digest_c_o = dig_c_q;
  assign digest_d_o = dig_d_q;

endmodule

// ===== rtl/core/md5bc_seq.sv =====
// Sequencer for word collection, round iteration, fold and digest handoff.
module md5bc_seq import md5bc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_start_i,
  input  logic       in_end_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output dp_ctl_t    ctl_o,
  output logic       wr_en_o,
  output logic [3:0] wr_addr_o,
  output logic [3:0] rd_addr_o
);

  seq_state_e state_q, state_d;
  logic [3:0] wpos_q, wpos_d;
  logic [5:0] rnd_q, rnd_d;
  logic       final_q, final_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, fold_stall;
  logic [3:0] wr_addr;
  logic [5:0] rd_rnd;

  assign in_acc     = in_valid_i && (state_q == ST_FILL);
  assign wr_addr    = in_start_i ? 4'd0 : wpos_q;
  assign fold_stall = final_q && out_valid_q && !out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc && wr_addr == 4'd15) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_PRIME;
      ST_PRIME: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!fold_stall) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    ctl_o.load_iv   = in_acc && in_start_i;
    ctl_o.load_work = (state_q == ST_LOAD);
    ctl_o.prime     = (state_q == ST_PRIME);
    ctl_o.round     = (state_q == ST_ROUND);
    ctl_o.fold      = (state_q == ST_FOLD) && !fold_stall;
    ctl_o.out_load  = ctl_o.fold && final_q;
    ctl_o.rnd       = rnd_q;
    unique case (state_q)
      ST_LOAD:  rd_rnd = 6'd0;
      ST_PRIME: rd_rnd = 6'd1;
      default:  rd_rnd = 6'(rnd_q + 6'd2);
    endcase
  end

  always_comb begin
    wpos_d = wpos_q;
    if (in_acc) begin
      wpos_d = 4'(wr_addr + 4'd1);
    end
    rnd_d = rnd_q;
    if (state_q == ST_PRIME) begin
      rnd_d = 6'd0;
    end else if (state_q == ST_ROUND) begin
      rnd_d = 6'(rnd_q + 6'd1);
    end
    final_d = final_q;
    if (in_acc) begin
      final_d = (final_q && !in_start_i) || in_end_i;
    end else if (ctl_o.out_load) begin
      final_d = 1'b0;
    end
    out_valid_d = ctl_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      wpos_q      <= 4'd0;
      rnd_q       <= 6'd0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      rnd_q       <= rnd_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_FILL);
  assign out_valid_o = out_valid_q;
  assign wr_en_o     = in_acc;
  assign wr_addr_o   = wr_addr;
  assign rd_addr_o   = msg_idx(rd_rnd);

  a_prime_to_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRIME) |=> (state_q == ST_ROUND && rnd_q == 6'd0))
    else $error("round counter not cleared on entry to rounds");

  a_digest_from_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FOLD && final_q))
    else $error("digest raised outside a final fold");

  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wr_addr == 4'd15) |=> (state_q == ST_LOAD && wpos_q == 4'd0))
    else $error("full block did not start compression");

endmodule

// ===== rtl/core/md5_block_compression.sv =====
// MD5 block compression: word collection, 64-round iteration and digest output.
// Sequence: after the sixteenth word transaction of a block, the sequencer steps through load,
//   prime, the 64 rounds and fold; a final block's digest is valid the cycle after the fold.
// Throughput: no words are accepted while a block is compressed; the compression rate is
//   set by the single round unit doing one round per cycle.
// Reset: chaining words to the MD5 initial values, sequencer, word position and final
//   flag cleared; the block buffer is not cleared.
module md5_block_compression import md5bc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5bc_in_if.sink    in_i,
  md5bc_out_if.source out_o
);

  dp_ctl_t          ctl;
  logic             wr_en;
  logic [3:0]       wr_addr;
  logic [3:0]       rd_addr;
  logic [WordW-1:0] rd_data;

  md5bc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_start_i  (in_i.start_message),
    .in_end_i    (in_i.end_message),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr)
  );

  md5bc_msg_mem u_msg_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.message_word),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5bc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .word_i     (rd_data),
    .digest_a_o (out_o.digest_a),
    .digest_b_o (out_o.digest_b),
    .digest_c_o (out_o.digest_c),
    .digest_d_o (out_o.digest_d)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the MD5 block compression core with a digest predictor.
module tb import md5bc_pkg::*;;

  localparam int unsigned TotalWords  = 1600;
  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } digest_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start_flag;
    logic             end_flag;
    logic             checked;
    digest_t          want;
  } stim_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam digest_t InitChain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
  localparam digest_t EmptyMsgDigest =
    '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ShiftAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  localparam stim_row_t Directed [25] = '{
    '{32'h00000080, 1'b1, 1'b1, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, 1'b1, EmptyMsgDigest},
    '{32'hffffffff, 1'b0, 1'b1, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0},
    '{32'hffffffff, 1'b0, 1'b0, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  md5bc_in_if  in_ch ();
  md5bc_out_if out_ch ();

  md5_block_compression dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  digest_t          chain_st;
  logic [WordW-1:0] blk_words [16];
  logic [3:0]       fill_pos;
  bit               final_mark;

  digest_t     digest_q [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  idle_mode_e  idle_mode = IDLE_NONE;
  bit          hold_go = 1'b0;
  bit          hold;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("md5_block_compression verification failed");
      $finish;
    end
  end

  function automatic bit absorb_word(input logic [WordW-1:0] w, input bit s, input bit e,
                                     output digest_t dg);
    logic [WordW-1:0] a, b, c, d, fn, sum, tmp;
    int idx;
    int sh;
    dg = '0;
    if (s) begin
      chain_st = InitChain;
      fill_pos = '0;
      final_mark = 1'b0;
    end
    if (e) final_mark = 1'b1;
    blk_words[fill_pos] = w;
    if (fill_pos != 4'd15) begin
      fill_pos = fill_pos + 4'd1;
      return 1'b0;
    end
    fill_pos = '0;
    a = chain_st.a;
    b = chain_st.b;
    c = chain_st.c;
    d = chain_st.d;
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          fn = (b & c) | (~b & d);
          idx = r;
        end
        1: begin
          fn = (b & d) | (c & ~d);
          idx = 5 * r + 1;
        end
        2: begin
          fn = b ^ c ^ d;
          idx = 3 * r + 5;
        end
        default: begin
          fn = c ^ (b | ~d);
          idx = 7 * r;
        end
      endcase
      sum = fn + a + RoundK[6'(r)] + blk_words[4'(idx)];
      sh = ShiftAmt[4'((r / 16) * 4 + r % 4)];
      tmp = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = tmp;
    end
    chain_st = '{chain_st.a + a, chain_st.b + b, chain_st.c + c, chain_st.d + d};
    if (!final_mark) return 1'b0;
    final_mark = 1'b0;
    dg = chain_st;
    return 1'b1;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input bit s, input bit e,
                           input bit checked, input digest_t want);
    digest_t dg;
    bit      got;
    int      pct;
    pct = (idle_mode == IDLE_SEND) ? 60 : (idle_mode == IDLE_BOTH) ? 17 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.message_word  <= w;
    in_ch.start_message <= s;
    in_ch.end_message   <= e;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    got = absorb_word(w, s, e, dg);
    if (checked) digest_q.push_back(want);
    else if (got) digest_q.push_back(dg);
    sent++;
  endtask

  task automatic send_message(input bit with_start);
    int nblk;
    int nwords;
    int lo;
    int endpos;
    nblk = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    nwords = with_start ? nblk * 16 : nblk * 16 - fill_pos;
    lo = (nwords > 16) ? nwords - 16 : 0;
    endpos = $urandom_range(nwords - 1, lo);
    for (int i = 0; i < nwords; i++) begin
      send_word(rand_word(), with_start && i == 0,
                i == endpos || (i >= lo && $urandom_range(0, 19) == 0), 1'b0, '0);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 24);
    repeat (n) begin
      send_word(rand_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    idle_mode_e mode;
    int         pick;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.message_word  <= '0;
    in_ch.start_message <= 1'b0;
    in_ch.end_message   <= 1'b0;
    chain_st = InitChain;
    fill_pos = '0;
    final_mark = 1'b0;
    foreach (blk_words[i]) blk_words[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (Directed[i]) begin
      send_word(Directed[i].word, Directed[i].start_flag, Directed[i].end_flag,
                Directed[i].checked, Directed[i].want);
    end
    // finish the block begun with all-ones words, chaining on from the empty-message digest
    send_message(1'b0);
    while (sent < TotalWords) begin
      mode = idle_mode_e'(sent * 4 / TotalWords);
      if (mode != idle_mode) begin
        if (mode == IDLE_SEND) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (digest_q.size() != 0);
        end
        if (mode == IDLE_RECV) hold_go = 1'b1;
        idle_mode = mode;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) send_noise();
      else send_message(pick != 1);
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("md5_block_compression verification clean");
    end else begin
      $display("md5_block_compression verification failed");
    end
    $finish;
  end

  initial begin : receiver_holdoff
    hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin : digest_sink
    digest_t want;
    digest_t got;
    int      pct;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      pct = (idle_mode == IDLE_RECV) ? 60 : (idle_mode == IDLE_BOTH) ? 17 : 0;
      out_ch.ready <= !hold && ($urandom_range(0, 99) >= pct);
      @(negedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.digest_a, out_ch.digest_b, out_ch.digest_c, out_ch.digest_d};
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports) $display("unexpected digest transaction: %h", got);
        end else begin
          want = digest_q.pop_front();
          if (got.a !== want.a || got.b !== want.b || got.c !== want.c || got.d !== want.d)
          begin
            errors++;
            if (errors <= MaxReports) begin
              $display("digest mismatch: expected a=%h b=%h c=%h d=%h, got a=%h b=%h c=%h d=%h",
                       want.a, want.b, want.c, want.d, got.a, got.b, got.c, got.d);
            end
          end
        end
      end
    end
  end

endmodule
